@@ design/axis_gesture_detector_defines.svh @@
// Assertion macros shared by the axis gesture detector checker.
`ifndef AXIS_GESTURE_DETECTOR_DEFINES_SVH
`define AXIS_GESTURE_DETECTOR_DEFINES_SVH

// Clocked assertion that is switched off while reset is applied.
`define AGD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds while reset is applied.
`define AGD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ design/agd_pkg.sv @@
// Types and constants of the axis gesture detector.
`timescale 1ns / 1ps
`default_nettype none

package agd_pkg;

  // Most events a single input beat can produce.
  localparam int unsigned EV_MAX = 3;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_WINDOW = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_INDEX    = 2'd3;
  localparam int unsigned CFG_DATA_W = 16;

  // Event codes.
  localparam logic [2:0] EV_MOTION     = 3'd0;
  localparam logic [2:0] EV_PRESS      = 3'd1;
  localparam logic [2:0] EV_DOUBLE     = 3'd2;
  localparam logic [2:0] EV_HOLD       = 3'd3;
  localparam logic [2:0] EV_DOUBLEHOLD = 3'd4;
  localparam logic [2:0] EV_RELEASE    = 3'd5;

  // Direction codes.
  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_POS  = 2'd1;
  localparam logic [1:0] DIR_NEG  = 2'd2;

  // Kind codes of an input beat.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Saturated value of the time since the last press.
  localparam logic [15:0] LONG_AGO = 16'hFFFF;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]         event_res;
    logic [1:0]         direction;
    logic signed [15:0] position;
    logic [7:0]         axis;
    logic               last;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] threshold;
    logic [15:0] hold_ticks;
    logic [15:0] double_window;
    logic [7:0]  axis_index;
  } cfg_t;

  // Events of one processed beat, in delivery order, with their count.
  typedef struct packed {
    out_beat_t [EV_MAX-1:0] ev;
    logic [1:0]             cnt;
  } ev_bundle_t;

  typedef enum logic [4:0] {
    GST_RELEASED   = 5'b00001,
    GST_PRESSED    = 5'b00010,
    GST_DOUBLE     = 5'b00100,
    GST_HELD       = 5'b01000,
    GST_DOUBLEHELD = 5'b10000
  } gst_e;

endpackage

`default_nettype wire

@@ design/axis_gesture_detector.sv @@
// Top level of the axis gesture detector.
`timescale 1ns / 1ps
`default_nettype none

// Axis gesture detector. Input beats are either signed Q1.15 axis samples or
// one millisecond ticks; each produces zero to three event beats on the output:
// a sample always gives a motion event, possibly followed by press, double
// press or release (a direction flip gives release and then press), and a tick
// gives a hold or double-press hold when the hold timer runs out. The last
// event of each input beat carries last set; a tick that causes nothing gives
// no output beat at all. An accepted beat is captured in an input register,
// runs through the combinational gesture logic and lands in a three-entry
// event buffer, from which the events are offered. The event buffer is the
// limit on rate: it takes a new beat's events in the cycle its last event
// leaves, and a new input beat is accepted while the previous events still
// drain. Configuration is written through the plain write port and must only
// change while the block is idle.

module axis_gesture_detector (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire agd_pkg::in_beat_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output agd_pkg::out_beat_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [agd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [agd_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import agd_pkg::*;

  cfg_t       cfg;
  ev_bundle_t evs;
  in_beat_t   in_q;
  logic       in_vld_q;
  logic       can_load;
  logic       fire;
  logic       in_acc;

  // The input register hands its beat on when the event buffer can take it.
  assign fire       = in_vld_q && can_load;
  assign in_stall_o = in_vld_q && !can_load;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (fire) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_data_i;
    end
  end

  agd_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  agd_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .beat_i (in_q),
    .cfg_i  (cfg),
    .evs_o  (evs)
  );

  agd_evq u_evq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .evs_i       (evs),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

@@ design/agd_cfg.sv @@
// Configuration registers of the axis gesture detector.
`timescale 1ns / 1ps
`default_nettype none

module agd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [agd_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [agd_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output agd_pkg::cfg_t                       cfg_o
);
  import agd_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_THRESHOLD:     cfg_d.threshold     = cfg_wdata_i;
        REG_HOLD_TICKS:    cfg_d.hold_ticks    = cfg_wdata_i;
        REG_DOUBLE_WINDOW: cfg_d.double_window = cfg_wdata_i;
        REG_AXIS_INDEX:    cfg_d.axis_index    = cfg_wdata_i[7:0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold     <= 16'd16384;
      cfg_q.hold_ticks    <= 16'd1000;
      cfg_q.double_window <= 16'd500;
      cfg_q.axis_index    <= 8'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ design/agd_core.sv @@
// Gesture state and the single-pass event logic of the axis gesture detector.
`timescale 1ns / 1ps
`default_nettype none

module agd_core (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               fire_i,
  input  wire agd_pkg::in_beat_t  beat_i,
  input  wire agd_pkg::cfg_t      cfg_i,
  output agd_pkg::ev_bundle_t     evs_o
);
  import agd_pkg::*;

  gst_e        gst_q, gst_d;
  logic [1:0]  adir_q, adir_d;
  logic [15:0] hrem_q, hrem_d;
  logic        hrun_q, hrun_d;
  logic [15:0] since_q, since_d;

  logic        neg;
  logic [16:0] mag;
  logic        act;
  logic [1:0]  dir;
  out_beat_t   blank;
  ev_bundle_t  evs;

  // Magnitude and direction of the sample; -32768 gives a magnitude of 32768.
  always_comb begin
    neg = beat_i.sample[15];
    mag = neg ? (17'h10000 - {1'b0, beat_i.sample}) : {1'b0, beat_i.sample};
    act = (mag >= {1'b0, cfg_i.threshold});
    dir = DIR_NONE;
    if (act) begin
      dir = (!neg && (beat_i.sample != 16'sd0)) ? DIR_POS : DIR_NEG;
    end
  end

  always_comb begin
    blank           = '0;
    blank.event_res = EV_MOTION;
    blank.direction = DIR_NONE;
    blank.axis      = cfg_i.axis_index;

    evs.ev  = {EV_MAX{blank}};
    evs.cnt = 2'd0;
    gst_d   = gst_q;
    adir_d  = adir_q;
    hrem_d  = hrem_q;
    hrun_d  = hrun_q;
    since_d = since_q;

    if (beat_i.kind == KIND_TICK) begin
      if (since_q != LONG_AGO) begin
        since_d = since_q + 16'd1;
      end
      if (hrun_q) begin
        if (hrem_q <= 16'd1) begin
          hrem_d = 16'd0;
          hrun_d = 1'b0;
          if (gst_q == GST_PRESSED) begin
            gst_d                 = GST_HELD;
            evs.ev[0].event_res   = EV_HOLD;
            evs.ev[0].direction   = adir_q;
            evs.cnt               = 2'd1;
          end else if (gst_q == GST_DOUBLE) begin
            gst_d                 = GST_DOUBLEHELD;
            evs.ev[0].event_res   = EV_DOUBLEHOLD;
            evs.ev[0].direction   = adir_q;
            evs.cnt               = 2'd1;
          end
        end else begin
          hrem_d = hrem_q - 16'd1;
        end
      end
    end else begin
      // Every sample is first echoed as motion.
      evs.ev[0].position = beat_i.sample;
      evs.cnt            = 2'd1;
      if (gst_q == GST_RELEASED) begin
        if (act) begin
          if ((since_q != LONG_AGO) && (since_q <= cfg_i.double_window)) begin
            since_d             = LONG_AGO;
            gst_d               = GST_DOUBLE;
            evs.ev[1].event_res = EV_DOUBLE;
          end else begin
            since_d             = 16'd0;
            gst_d               = GST_PRESSED;
            evs.ev[1].event_res = EV_PRESS;
          end
          evs.ev[1].direction = dir;
          evs.cnt             = 2'd2;
          hrem_d              = cfg_i.hold_ticks;
          hrun_d              = 1'b1;
        end
      end else if (!act) begin
        gst_d               = GST_RELEASED;
        evs.ev[1].event_res = EV_RELEASE;
        evs.cnt             = 2'd2;
        hrun_d              = 1'b0;
        hrem_d              = 16'd0;
      end else if (dir != adir_q) begin
        // A direction flip releases and presses again, never a double press.
        evs.ev[1].event_res = EV_RELEASE;
        evs.ev[2].event_res = EV_PRESS;
        evs.ev[2].direction = dir;
        evs.cnt             = 2'd3;
        since_d             = 16'd0;
        gst_d               = GST_PRESSED;
        hrem_d              = cfg_i.hold_ticks;
        hrun_d              = 1'b1;
      end
      adir_d = dir;
    end

    unique case (evs.cnt)
      2'd1:    evs.ev[0].last = 1'b1;
      2'd2:    evs.ev[1].last = 1'b1;
      2'd3:    evs.ev[2].last = 1'b1;
      default: evs.ev[0].last = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gst_q   <= GST_RELEASED;
      adir_q  <= DIR_NONE;
      hrem_q  <= 16'd0;
      hrun_q  <= 1'b0;
      since_q <= LONG_AGO;
    end else if (fire_i) begin
      gst_q   <= gst_d;
      adir_q  <= adir_d;
      hrem_q  <= hrem_d;
      hrun_q  <= hrun_d;
      since_q <= since_d;
    end
  end

  assign evs_o = evs;

endmodule

`default_nettype wire

@@ design/agd_evq.sv @@
// Event buffer of the axis gesture detector: holds one beat's events and drains them.
`timescale 1ns / 1ps
`default_nettype none

module agd_evq (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire agd_pkg::ev_bundle_t evs_i,
  output logic                     can_load_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output agd_pkg::out_beat_t       out_data_o
);
  import agd_pkg::*;

  out_beat_t  slot_q [EV_MAX];
  out_beat_t  slot_d [EV_MAX];
  logic [1:0] cnt_q, cnt_d;
  logic       out_acc;

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  // The buffer takes new events once its last one leaves.
  assign can_load_o  = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_acc);

  always_comb begin
    slot_d = slot_q;
    cnt_d  = cnt_q;
    if (load_i) begin
      slot_d[0] = evs_i.ev[0];
      slot_d[1] = evs_i.ev[1];
      slot_d[2] = evs_i.ev[2];
      cnt_d     = evs_i.cnt;
    end else if (out_acc) begin
      slot_d[0] = slot_q[1];
      slot_d[1] = slot_q[2];
      cnt_d     = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign out_data_o = slot_q[0];

endmodule

`default_nettype wire

@@ design/agd_checker.sv @@
// Port-level assertions of the axis gesture detector and their bind.
`timescale 1ns / 1ps
`default_nettype none
`include "axis_gesture_detector_defines.svh"

module agd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire agd_pkg::out_beat_t out_data_o
);
  import agd_pkg::*;

  // A stalled output beat stays offered and unchanged.
  `AGD_ASSERT(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o), "output beat changed while stalled")

  // Reset leaves the event buffer empty by the next edge.
  `AGD_ASSERT_RST(a_rst_empty, !rst_ni |=> !out_valid_o, "output valid after reset")

  // Events of one input beat follow each other without a gap.
  `AGD_ASSERT(a_burst, out_valid_o && !out_stall_i && !out_data_o.last |=> out_valid_o, "gap inside the events of one beat")

  // Motion and release carry no direction; every other event always does.
  `AGD_ASSERT(a_dir, out_valid_o |-> (((out_data_o.event_res == EV_MOTION) || (out_data_o.event_res == EV_RELEASE)) == (out_data_o.direction == DIR_NONE)), "event direction inconsistent")

endmodule

bind axis_gesture_detector agd_checker u_agd_checker (.*);

`default_nettype wire

@@ tb/sv/testbench.sv @@
// Self-checking testbench of the axis gesture detector, with its gesture tracker.
`timescale 1ns / 1ps

module testbench;
  import agd_pkg::*;

  // The limit allows for the slowest correct run, which assumes three events
  // per beat, each behind a heavily stalled receiver, and slow senders and the
  // drains between settings on top, and it leaves a wide margin above that.
  localparam int unsigned LIMIT_CYCLES   = 300000;
  localparam int unsigned HOLDOFF_CYCLES = 80;
  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned BEATS_PER_PHASE = 32;

  // Tracks the gesture state of the axis. It predicts the events of every
  // accepted input beat and holds them until the block delivers them.
  class gesture_tracker;
    cfg_t        cfg;
    gst_e        gst;
    logic [1:0]  held_dir;
    logic [15:0] hold_left;
    bit          hold_on;
    logic [15:0] since_press;
    out_beat_t   pending_events[$];
    int          errors;
    int          beats;
    int          ticks;
    int          ev_seen[6];

    function new();
      cfg.threshold     = 16'd16384;
      cfg.hold_ticks    = 16'd1000;
      cfg.double_window = 16'd500;
      cfg.axis_index    = 8'd0;
      gst         = GST_RELEASED;
      held_dir    = DIR_NONE;
      hold_left   = '0;
      hold_on     = 1'b0;
      since_press = LONG_AGO;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_THRESHOLD:     cfg.threshold     = val;
        REG_HOLD_TICKS:    cfg.hold_ticks    = val;
        REG_DOUBLE_WINDOW: cfg.double_window = val;
        REG_AXIS_INDEX:    cfg.axis_index    = val[7:0];
        default: ;
      endcase
    endfunction

    function out_beat_t make_ev(logic [2:0] code, logic [1:0] dir, logic [15:0] pos);
      out_beat_t e;
      e.event_res = code;
      e.direction = dir;
      e.position  = pos;
      e.axis      = cfg.axis_index;
      e.last      = 1'b0;
      return e;
    endfunction

    function void take_beat(in_beat_t b);
      out_beat_t   evs[$];
      out_beat_t   e;
      logic [16:0] mag;
      logic [1:0]  dir;
      beats++;
      if (b.kind == KIND_TICK) begin
        ticks++;
        if (since_press != LONG_AGO) since_press++;
        if (hold_on) begin
          if (hold_left <= 16'd1) begin
            // The timer runs out; only the two pressed states turn into holds.
            hold_left = '0;
            hold_on   = 1'b0;
            if (gst == GST_PRESSED) begin
              gst = GST_HELD;
              evs.push_back(make_ev(EV_HOLD, held_dir, '0));
            end else if (gst == GST_DOUBLE) begin
              gst = GST_DOUBLEHELD;
              evs.push_back(make_ev(EV_DOUBLEHOLD, held_dir, '0));
            end
          end else begin
            hold_left--;
          end
        end
      end else begin
        mag = b.sample[15] ? (17'h10000 - {1'b0, b.sample}) : {1'b0, b.sample};
        dir = DIR_NONE;
        // A zero sample that reaches a zero threshold counts as negative.
        if (mag >= {1'b0, cfg.threshold}) begin
          dir = (!b.sample[15] && b.sample != 16'sd0) ? DIR_POS : DIR_NEG;
        end
        evs.push_back(make_ev(EV_MOTION, DIR_NONE, b.sample));
        if (gst == GST_RELEASED) begin
          if (dir != DIR_NONE) begin
            if (since_press != LONG_AGO && since_press <= cfg.double_window) begin
              since_press = LONG_AGO;
              gst = GST_DOUBLE;
              evs.push_back(make_ev(EV_DOUBLE, dir, '0));
            end else begin
              since_press = '0;
              gst = GST_PRESSED;
              evs.push_back(make_ev(EV_PRESS, dir, '0));
            end
            hold_left = cfg.hold_ticks;
            hold_on   = 1'b1;
          end
        end else if (dir == DIR_NONE) begin
          gst = GST_RELEASED;
          evs.push_back(make_ev(EV_RELEASE, DIR_NONE, '0));
          hold_on   = 1'b0;
          hold_left = '0;
        end else if (dir != held_dir) begin
          // A direction flip releases and presses again in one beat.
          evs.push_back(make_ev(EV_RELEASE, DIR_NONE, '0));
          since_press = '0;
          gst = GST_PRESSED;
          evs.push_back(make_ev(EV_PRESS, dir, '0));
          hold_left = cfg.hold_ticks;
          hold_on   = 1'b1;
        end
        held_dir = dir;
      end
      foreach (evs[i]) begin
        e = evs[i];
        e.last = (i == evs.size() - 1);
        pending_events.push_back(e);
      end
    endfunction

    function void match_event(out_beat_t got);
      out_beat_t want;
      if (pending_events.size() == 0) begin
        errors++;
        if (errors <= 10) begin
          $display("unexpected event: ev=%0d dir=%0d pos=%0d axis=%0d last=%0d",
                   got.event_res, got.direction, got.position, got.axis, got.last);
        end
        return;
      end
      want = pending_events.pop_front();
      if (got.event_res !== want.event_res || got.direction !== want.direction ||
          got.position !== want.position || got.axis !== want.axis ||
          got.last !== want.last) begin
        errors++;
        if (errors <= 10) begin
          $display("event mismatch: expected ev=%0d dir=%0d pos=%0d axis=%0d last=%0d",
                   want.event_res, want.direction, want.position, want.axis, want.last);
          $display("                got      ev=%0d dir=%0d pos=%0d axis=%0d last=%0d",
                   got.event_res, got.direction, got.position, got.axis, got.last);
        end
      end else if (got.event_res <= EV_RELEASE) begin
        ev_seen[got.event_res]++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_beat_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  gesture_tracker trk;
  int unsigned    cycle_cnt = 0;
  int             gap_pct   = 6;
  int             stall_pct = 87;
  int             settings  = 0;
  // The stimulus bumps holdoff_req to ask for one long receiver hold-off.
  int             holdoff_req  = 0;
  int             holdoff_seen = 0;
  int             holdoff_left = 0;

  axis_gesture_detector dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit. A hung handshake or a missing event ends up here.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt == LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // The receiver stalls at random. On request it holds off for a long
  // stretch so that the event buffer fills up and the input stalls too.
  always @(posedge clk_i) begin
    if (holdoff_req != holdoff_seen) begin
      holdoff_seen = holdoff_req;
      holdoff_left = HOLDOFF_CYCLES;
    end
    if (holdoff_left > 0) begin
      holdoff_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99, 0) < stall_pct);
    end
  end

  // Every event beat that the block hands over is checked against the
  // oldest prediction. Values are read before this edge's updates land.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      trk.match_event(out_data_o);
    end
  end

  function automatic in_beat_t mk_sample(logic [15:0] s);
    in_beat_t b;
    b.kind   = KIND_SAMPLE;
    b.sample = s;
    return b;
  endfunction

  function automatic in_beat_t mk_tick();
    in_beat_t b;
    b.kind   = KIND_TICK;
    b.sample = 16'($urandom);
    return b;
  endfunction

  // A sample that reaches the threshold, negative when asked or when only a negative one can.
  function automatic logic [15:0] active_level(bit negative, int thr);
    int m;
    if (negative || thr > 32767) begin
      m = $urandom_range(32768, (thr == 0) ? 1 : thr);
      return 16'(-m);
    end
    m = $urandom_range(32767, thr);
    return 16'(m);
  endfunction

  // A sample below a nonzero threshold, of either sign; zero when the threshold is zero.
  function automatic logic [15:0] quiet_level(int thr);
    int m;
    if (thr == 0) return 16'd0;
    m = $urandom_range((thr > 32768) ? 32767 : thr - 1, 0);
    return $urandom_range(1, 0) ? 16'(-m) : 16'(m);
  endfunction

  // Offers one beat and returns in the step after the edge that took it.
  // Valid stays high there, so a following beat can go out back to back.
  task automatic send_beat(in_beat_t b);
    while ($urandom_range(99, 0) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) @(posedge clk_i);
    trk.take_beat(b);
  endtask

  // Stops offering beats and waits until every predicted event has come.
  // A tick without events may still be in flight, so the task then waits the number of cycles given in extra.
  task automatic settle(int unsigned extra);
    in_valid_i <= 1'b0;
    while (trk.pending_events.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  // Writes all four registers, one per cycle, once the block is idle.
  task automatic program_regs(int thr, int hold, int win, int axis_no);
    logic [CFG_IDX_W-1:0]  idx_list[4];
    logic [CFG_DATA_W-1:0] val_list[4];
    idx_list = '{REG_THRESHOLD, REG_HOLD_TICKS, REG_DOUBLE_WINDOW, REG_AXIS_INDEX};
    val_list = '{16'(thr), 16'(hold), 16'(win), 16'(axis_no)};
    settle(DRAIN_CYCLES);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= idx_list[i];
      cfg_wdata_i <= val_list[i];
      @(posedge clk_i);
      trk.set_reg(idx_list[i], val_list[i]);
    end
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  // Hand-picked beats through every gesture transition and corner case.
  task automatic run_directed();
    // Reset settings: threshold at one half, long hold and window.
    send_beat(mk_sample(16'sd0));         // motion only
    send_beat(mk_sample(16'sd16384));     // first press after reset is a plain press
    send_beat(mk_sample(16'sd32767));     // same direction: motion only
    send_beat(mk_sample(-16'sd32768));    // flip: release, then press
    send_beat(mk_sample(16'sd100));       // release
    send_beat(mk_tick());                 // timer stopped: nothing
    send_beat(mk_sample(-16'sd16384));    // inside the window: double press
    send_beat(mk_sample(16'sd0));         // release
    send_beat(mk_sample(16'sd20000));     // a double press leaves the last one long ago
    // Zero threshold and zero hold time; every sample is active.
    program_regs(0, 0, 0, 255);
    send_beat(mk_sample(16'sd0));         // zero counts as negative: flip
    send_beat(mk_tick());                 // zero hold time expires at once: hold
    send_beat(mk_tick());                 // held: nothing
    send_beat(mk_sample(16'sd1));         // flip out of held
    // Threshold only reachable by the most negative sample.
    program_regs(32768, 65535, 65535, 8'h5A);
    send_beat(mk_sample(16'sd32767));     // not active: release
    send_beat(mk_tick());
    send_beat(mk_sample(-16'sd32768));    // widest window: double press
    send_beat(mk_tick());                 // long hold: nothing
    send_beat(mk_sample(16'sd0));         // release
    // Short timer and window for hold and double-press hold.
    program_regs(8000, 2, 3, 7);
    send_beat(mk_sample(16'sd9000));      // press
    send_beat(mk_tick());
    send_beat(mk_tick());                 // hold
    send_beat(mk_sample(-16'sd100));      // release
    send_beat(mk_tick());
    send_beat(mk_sample(-16'sd9000));     // double press
    send_beat(mk_tick());
    send_beat(mk_tick());                 // double-press hold
  endtask

  // One gesture: activation, ticks mixed with further samples and flips,
  // then a release and a pause that may or may not lead to a double press.
  task automatic run_gesture();
    int thr;
    int n;
    int r;
    bit neg;
    thr = trk.cfg.threshold;
    neg = 1'($urandom_range(1, 0));
    send_beat(mk_sample(active_level(neg, thr)));
    n = $urandom_range(trk.cfg.hold_ticks + 2, 0);
    repeat (n) begin
      r = $urandom_range(99, 0);
      if (r < 15) begin
        send_beat(mk_sample(active_level(neg, thr)));
      end else if (r < 22) begin
        neg = !neg;
        send_beat(mk_sample(active_level(neg, thr)));
      end else begin
        send_beat(mk_tick());
      end
    end
    send_beat(mk_sample(quiet_level(thr)));
    n = $urandom_range((trk.cfg.double_window > 10) ? 12 : trk.cfg.double_window + 2, 0);
    repeat (n) send_beat(mk_tick());
  endtask

  // Mostly whole gestures, with some unrelated beats of any content.
  task automatic run_random(int count);
    int target;
    in_beat_t b;
    target = trk.beats + count;
    while (trk.beats < target) begin
      if ($urandom_range(3, 0) == 0) begin
        b.kind   = 1'($urandom_range(1, 0));
        b.sample = 16'($urandom);
        send_beat(b);
      end else begin
        run_gesture();
      end
    end
  endtask

  initial begin
    trk = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Slow receiver first.
    gap_pct   = 6;
    stall_pct = 87;
    run_directed();
    program_regs($urandom_range(30000, 1000), $urandom_range(8, 1), $urandom_range(10, 0),
                 $urandom_range(255, 0));
    run_random(BEATS_PER_PHASE);

    // Slow sender.
    gap_pct   = 87;
    stall_pct = 6;
    program_regs($urandom_range(30000, 1000), $urandom_range(8, 1), $urandom_range(10, 0),
                 $urandom_range(255, 0));
    run_random(BEATS_PER_PHASE);

    // Full rate, starting with a long receiver hold-off while beats keep coming.
    gap_pct   = 0;
    stall_pct = 0;
    program_regs($urandom_range(30000, 1000), $urandom_range(8, 1), $urandom_range(10, 0),
                 $urandom_range(255, 0));
    holdoff_req++;
    run_random(BEATS_PER_PHASE);

    settle(3 * DRAIN_CYCLES);
    $display("Covered %0d input beats (%0d ticks) over %0d register settings.",
             trk.beats, trk.ticks, settings);
    $display("Matched %0d motion, %0d press, %0d double, %0d hold, %0d double hold, %0d release.",
             trk.ev_seen[EV_MOTION], trk.ev_seen[EV_PRESS], trk.ev_seen[EV_DOUBLE],
             trk.ev_seen[EV_HOLD], trk.ev_seen[EV_DOUBLEHOLD], trk.ev_seen[EV_RELEASE]);
    if (trk.errors == 0 && trk.pending_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+design
design/agd_pkg.sv
design/agd_cfg.sv
design/agd_core.sv
design/agd_evq.sv
design/axis_gesture_detector.sv
design/agd_checker.sv
tb/sv/testbench.sv
